// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define CSDF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CSDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/csdf_pkg.sv =====
// ----------------------------------------------------------------------------
// csdf_pkg
// Grid geometry, fixed point helpers, codes and shared types of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csdf_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 48;
   localparam int FRAC_BITS   = 16;

   localparam int NCELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int IDX_W   = $clog2(NCELLS);
   localparam int ROW_W   = $clog2(GRID_HEIGHT);
   localparam int COL_W   = $clog2(GRID_WIDTH);
   localparam int NTAPS   = 12;
   localparam int TAP_W   = $clog2(NTAPS);
   localparam int ISSUE_LAST = NTAPS + 2;
   localparam int ISSUE_W = $clog2(ISSUE_LAST + 1);
   localparam int VSUM_W  = IDX_W + 33;
   localparam int ACC_W   = 40;

   localparam int EPS = ((1 << FRAC_BITS) + 50) / 100;
   localparam logic [23:0] FAR_SAMPLE = 24'(100 << 16);
   localparam logic signed [31:0] VEL_ONE = 32'(1 << FRAC_BITS);

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_READ = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CSR_TRACTION = 3'd0,
      CSR_SHEAR    = 3'd1,
      CSR_FLEXION  = 3'd2,
      CSR_PUSH     = 3'd3,
      CSR_STEP     = 3'd4,
      CSR_THRESH   = 3'd5,
      CSR_MAX_ITER = 3'd6,
      CSR_ERASE    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_EDGE,
      KIND_DIAG,
      KIND_FLEX
   } kind_type;

   localparam int NBR_DR [NTAPS] = '{-1, 1, 0, 0, -1, -1, 1, 1, -2, 2, 0, 0};
   localparam int NBR_DC [NTAPS] = '{0, 0, -1, 1, -1, 1, 1, -1, 0, 0, -2, 2};
   localparam kind_type NBR_KIND [NTAPS] = '{
      KIND_EDGE, KIND_EDGE, KIND_EDGE, KIND_EDGE,
      KIND_DIAG, KIND_DIAG, KIND_DIAG, KIND_DIAG,
      KIND_FLEX, KIND_FLEX, KIND_FLEX, KIND_FLEX
   };

   typedef struct packed {
      logic               valid;
      logic signed [32:0] operand;
      logic [15:0]        gain;
   } mac_req_type;

   typedef struct packed {
      logic               valid;
      logic signed [33:0] result;
   } mac_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
         return $signed(32'h8000_0000);
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] sample_to_fix(input logic [23:0] s);
      logic [63:0] v;
      if (FRAC_BITS >= 16) begin
         v = 64'(s) << (FRAC_BITS - 16);
      end else begin
         v = 64'(s) >> (16 - FRAC_BITS);
      end
      if (v > 64'h0000_0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/csdf_req_if.sv =====
// ----------------------------------------------------------------------------
// csdf_req_if
// Request channel: mode, cell index and depth sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface csdf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [11:0] cell_index;
   logic [23:0] depth_sample;

   modport source(output valid, mode, cell_index, depth_sample, input ready);
   modport sink(input valid, mode, cell_index, depth_sample, output ready);
endinterface

`default_nettype wire

// ===== src/csdf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// csdf_rsp_if
// Response channel: barrier flag, cloth depth and run status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface csdf_rsp_if;
   logic               valid;
   logic               ready;
   logic               barrier_flag;
   logic signed [31:0] cloth_depth;
   logic [15:0]        iterations_used;
   logic               converged;

   modport source(output valid, barrier_flag, cloth_depth, iterations_used, converged,
                  input ready);
   modport sink(input valid, barrier_flag, cloth_depth, iterations_used, converged,
                output ready);
endinterface

`default_nettype wire

// ===== src/csdf_mac.sv =====
// ----------------------------------------------------------------------------
// csdf_mac
// Shared multiplier: signed operand times Q0.16 gain, rounded half up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csdf_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  csdf_pkg::mac_req_type mac_req,
   output csdf_pkg::mac_rsp_type mac_rsp
);

   logic signed [49:0] product;
   logic               valid_ff;
   logic signed [33:0] result_ff;

   assign product = $signed(mac_req.operand) * $signed({1'b0, mac_req.gain})
                    + 50'sd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= mac_req.valid;
      end
      result_ff <= product[49:16];
   end

   assign mac_rsp.valid  = valid_ff;
   assign mac_rsp.result = result_ff;

endmodule

`default_nettype wire

// ===== src/cloth_simulation_depth_filter.sv =====
// ----------------------------------------------------------------------------
// cloth_simulation_depth_filter
// Drapes a fixed point cloth over a loaded depth grid and reads it back.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries mode, cell_index and depth_sample. A load request writes
//   one sample, so loads stream at one per cycle. A run request scans the
//   grid for its minimum, seeds the cloth, then per iteration does collision,
//   force (a centre read plus twelve neighbour reads of the cloth memory, the
//   neighbour terms going through the one shared multiplier) and update, and
//   gives one response with iterations_used and converged. A read request
//   returns the barrier flag and cloth depth of one cell.
//   req_bus.ready is high only while no run or read is in progress.
//   Responses sit in an output register; a stalled receiver holds the
//   response and the next run or read waits at its end until the register
//   frees. Reset returns the registers to their defaults, clears the run
//   status and makes reads return zero until the first run.
//   csr_write writes csr_data to register csr_index; the user must write
//   only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cloth_simulation_depth_filter (
   input  logic              clock,
   input  logic              reset,
   csdf_req_if.sink          req_bus,
   csdf_rsp_if.source        rsp_bus,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [40:0]       csr_data
);

   localparam int IW = csdf_pkg::IDX_W;
   localparam int RW = csdf_pkg::ROW_W;
   localparam int CW = csdf_pkg::COL_W;
   localparam int SW = csdf_pkg::ISSUE_W;
   localparam int VW = csdf_pkg::VSUM_W;
   localparam int AW = csdf_pkg::ACC_W;
   localparam int TAP_SEL_W = csdf_pkg::TAP_W;

   typedef enum logic [3:0] {
      S_IDLE, S_MIN_RD, S_MIN_ACC, S_INIT, S_ITER, S_COL_RD, S_COL_WR,
      S_FRC, S_FRC_WR, S_UPD_RD, S_UPD_MAC, S_UPD_WR, S_CHECK,
      S_READ_RD, S_READ_OUT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]        traction_ff, traction_in, shear_ff, shear_in, flexion_ff, flexion_in;
   logic signed [31:0] push_ff, push_in;
   logic [15:0]        step_ff, step_in, max_iter_ff, max_iter_in;
   logic signed [40:0] thresh_ff, thresh_in;
   logic [5:0]         erase_rows_ff, erase_rows_in;

   logic [IW-1:0]      idx_ff, idx_in, cell_ff, cell_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [SW-1:0]      issue_ff, issue_in;
   logic [15:0]        iter_ff, iter_in;
   logic               conv_ff, conv_in, ran_ff, ran_in;
   logic [23:0]        min_ff, min_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [31:0] centre_ff, centre_in, vel_new_ff, vel_new_in;
   logic signed [VW-1:0] vsum_ff, vsum_in;
   logic               erase_ff, erase_in;
   logic               s1_valid_ff, s1_valid_in, s1_centre_ff, s1_centre_in;
   logic [15:0]        s1_gain_ff, s1_gain_in;
   logic               res_barrier_ff, res_barrier_in;
   logic signed [31:0] res_depth_ff, res_depth_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_barrier_ff, rsp_barrier_in;
   logic signed [31:0] rsp_depth_ff, rsp_depth_in;
   logic [15:0]        rsp_iters_ff, rsp_iters_in;
   logic               rsp_conv_ff, rsp_conv_in;

   logic [23:0]        image_mem [csdf_pkg::NCELLS];
   logic signed [31:0] cloth_mem [csdf_pkg::NCELLS];
   logic signed [31:0] vel_mem   [csdf_pkg::NCELLS];
   logic signed [31:0] force_mem [csdf_pkg::NCELLS];
   logic               free_mem  [csdf_pkg::NCELLS];

   logic [23:0]        image_rd_ff;
   logic signed [31:0] cloth_rd_ff, vel_rd_ff, force_rd_ff;
   logic               free_rd_ff;

   logic               image_we, cloth_we, vel_we, free_we, force_we;
   logic [23:0]        image_wd;
   logic signed [31:0] cloth_wd, vel_wd, force_wd;
   logic               free_wd;
   logic [IW-1:0]      cloth_raddr, free_raddr;

   csdf_pkg::mac_req_type mac_req;
   csdf_pkg::mac_rsp_type mac_rsp;

   logic               req_fire, cell_ok, last_cell;
   logic [IW-1:0]      req_cell;
   logic [15:0]        er_sat;
   logic               row_far;
   logic [IW-1:0]      idx_next;
   logic [RW-1:0]      row_next;
   logic [CW-1:0]      col_next;
   logic signed [31:0] img_fix, start_fix, vel_sum, cloth_new;
   logic signed [32:0] gap;
   logic [23:0]        eff_sample;
   logic [TAP_SEL_W-1:0] tap_sel;
   logic               tap_live;
   logic signed [RW+1:0] nbr_row;
   logic signed [CW+1:0] nbr_col;
   logic signed [IW+1:0] nbr_addr;
   logic               nbr_ok;
   logic [15:0]        tap_gain;

   csdf_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_req (mac_req),
      .mac_rsp (mac_rsp)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_cell      = IW'(req_bus.cell_index);
   assign cell_ok       = 32'(req_bus.cell_index) < 32'(csdf_pkg::NCELLS);

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.barrier_flag    = rsp_barrier_ff;
   assign rsp_bus.cloth_depth     = rsp_depth_ff;
   assign rsp_bus.iterations_used = rsp_iters_ff;
   assign rsp_bus.converged       = rsp_conv_ff;

   assign er_sat  = (16'(erase_rows_ff) > 16'(csdf_pkg::GRID_HEIGHT)) ?
                    16'(csdf_pkg::GRID_HEIGHT) : 16'(erase_rows_ff);
   assign row_far = 16'(row_ff) >= (16'(csdf_pkg::GRID_HEIGHT) - er_sat);

   assign last_cell = (idx_ff == IW'(csdf_pkg::NCELLS - 1));
   assign col_next  = (col_ff == CW'(csdf_pkg::GRID_WIDTH - 1)) ? '0 : col_ff + 1'b1;
   assign row_next  = last_cell ? '0 :
                      ((col_ff == CW'(csdf_pkg::GRID_WIDTH - 1)) ? row_ff + 1'b1 : row_ff);
   assign idx_next  = last_cell ? '0 : idx_ff + 1'b1;

   assign eff_sample = erase_ff ? csdf_pkg::FAR_SAMPLE : image_rd_ff;
   assign img_fix    = csdf_pkg::sample_to_fix(eff_sample);
   assign start_fix  = csdf_pkg::sample_to_fix(min_ff);
   assign gap        = 33'(img_fix) - 33'(cloth_rd_ff);

   assign tap_live = (issue_ff >= SW'(1)) && (issue_ff <= SW'(csdf_pkg::NTAPS));
   assign tap_sel  = tap_live ? TAP_SEL_W'(issue_ff - SW'(1)) : '0;
   assign nbr_row  = $signed({2'b00, row_ff}) + (RW + 2)'(csdf_pkg::NBR_DR[tap_sel]);
   assign nbr_col  = $signed({2'b00, col_ff}) + (CW + 2)'(csdf_pkg::NBR_DC[tap_sel]);
   assign nbr_addr = $signed({2'b00, idx_ff})
                     + (IW + 2)'(csdf_pkg::NBR_DR[tap_sel] * csdf_pkg::GRID_WIDTH
                                 + csdf_pkg::NBR_DC[tap_sel]);
   assign nbr_ok   = (nbr_row >= 0) && (nbr_row < (RW + 2)'(csdf_pkg::GRID_HEIGHT))
                     && (nbr_col >= 0) && (nbr_col < (CW + 2)'(csdf_pkg::GRID_WIDTH));

   always_comb begin
      case (csdf_pkg::NBR_KIND[tap_sel])
         csdf_pkg::KIND_EDGE: tap_gain = traction_ff;
         csdf_pkg::KIND_DIAG: tap_gain = shear_ff;
         csdf_pkg::KIND_FLEX: tap_gain = flexion_ff;
         default:             tap_gain = traction_ff;
      endcase
   end

   assign vel_sum   = csdf_pkg::sat32(64'(vel_rd_ff) + 64'(force_rd_ff));
   assign cloth_new = csdf_pkg::sat32(64'(cloth_rd_ff) + 64'(mac_rsp.result));

   always_comb begin
      case (state_ff)
         S_FRC:     cloth_raddr = (issue_ff == '0) ? idx_ff : nbr_addr[IW-1:0];
         S_READ_RD: cloth_raddr = cell_ff;
         default:   cloth_raddr = idx_ff;
      endcase
      free_raddr = (state_ff == S_READ_RD) ? cell_ff : idx_ff;
   end

   always_comb begin
      mac_req.valid   = 1'b0;
      mac_req.operand = 33'(cloth_rd_ff) - 33'(centre_ff);
      mac_req.gain    = s1_gain_ff;
      if (state_ff == S_FRC) begin
         mac_req.valid = s1_valid_ff && !s1_centre_ff;
      end else if (state_ff == S_UPD_MAC) begin
         mac_req.valid   = 1'b1;
         mac_req.operand = 33'(vel_new_in);
         mac_req.gain    = step_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      cell_in        = cell_ff;
      issue_in       = issue_ff;
      iter_in        = iter_ff;
      conv_in        = conv_ff;
      ran_in         = ran_ff;
      min_in         = min_ff;
      acc_in         = acc_ff;
      centre_in      = centre_ff;
      vel_new_in     = vel_new_ff;
      vsum_in        = vsum_ff;
      erase_in       = row_far;
      s1_valid_in    = 1'b0;
      s1_centre_in   = 1'b0;
      s1_gain_in     = tap_gain;
      res_barrier_in = res_barrier_ff;
      res_depth_in   = res_depth_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_barrier_in = rsp_barrier_ff;
      rsp_depth_in   = rsp_depth_ff;
      rsp_iters_in   = rsp_iters_ff;
      rsp_conv_in    = rsp_conv_ff;
      image_we = 1'b0;  image_wd = req_bus.depth_sample;
      cloth_we = 1'b0;  cloth_wd = start_fix;
      vel_we   = 1'b0;  vel_wd   = csdf_pkg::VEL_ONE;
      free_we  = 1'b0;  free_wd  = 1'b1;
      force_we = 1'b0;  force_wd = csdf_pkg::sat32(64'(acc_ff));

      traction_in   = traction_ff;
      shear_in      = shear_ff;
      flexion_in    = flexion_ff;
      push_in       = push_ff;
      step_in       = step_ff;
      thresh_in     = thresh_ff;
      max_iter_in   = max_iter_ff;
      erase_rows_in = erase_rows_ff;
      if (csr_write) begin
         case (csr_index)
            csdf_pkg::CSR_TRACTION: traction_in   = csr_data[15:0];
            csdf_pkg::CSR_SHEAR:    shear_in      = csr_data[15:0];
            csdf_pkg::CSR_FLEXION:  flexion_in    = csr_data[15:0];
            csdf_pkg::CSR_PUSH:     push_in       = csr_data[31:0];
            csdf_pkg::CSR_STEP:     step_in       = csr_data[15:0];
            csdf_pkg::CSR_THRESH:   thresh_in     = csr_data;
            csdf_pkg::CSR_MAX_ITER: max_iter_in   = csr_data[15:0];
            csdf_pkg::CSR_ERASE:    erase_rows_in = csr_data[5:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_bus.mode == csdf_pkg::MODE_LOAD) begin
                  image_we = cell_ok;
               end else if (req_bus.mode == csdf_pkg::MODE_RUN) begin
                  idx_in   = '0;
                  row_in   = '0;
                  col_in   = '0;
                  min_in   = 24'hFF_FFFF;
                  conv_in  = 1'b0;
                  iter_in  = '0;
                  ran_in   = 1'b1;
                  state_in = S_MIN_RD;
               end else if (req_bus.mode == csdf_pkg::MODE_READ) begin
                  cell_in        = req_cell;
                  res_barrier_in = 1'b0;
                  res_depth_in   = '0;
                  state_in       = (ran_ff && cell_ok) ? S_READ_RD : S_DONE;
               end
            end
         end
         S_MIN_RD: state_in = S_MIN_ACC;
         S_MIN_ACC: begin
            if (eff_sample < min_ff) begin
               min_in = eff_sample;
            end
            idx_in   = idx_next;
            row_in   = row_next;
            col_in   = col_next;
            state_in = last_cell ? S_INIT : S_MIN_RD;
         end
         S_INIT: begin
            cloth_we = 1'b1;
            vel_we   = 1'b1;
            free_we  = 1'b1;
            idx_in   = idx_next;
            row_in   = row_next;
            col_in   = col_next;
            state_in = last_cell ? S_ITER : S_INIT;
         end
         S_ITER: begin
            if (iter_ff >= max_iter_ff) begin
               res_barrier_in = 1'b0;
               res_depth_in   = '0;
               state_in       = S_DONE;
            end else begin
               iter_in  = iter_ff + 16'd1;
               state_in = S_COL_RD;
            end
         end
         S_COL_RD: state_in = S_COL_WR;
         S_COL_WR: begin
            free_we  = 1'b1;
            free_wd  = gap > $signed(33'(csdf_pkg::EPS));
            cloth_we = gap < $signed(33'(csdf_pkg::EPS));
            cloth_wd = img_fix;
            idx_in   = idx_next;
            row_in   = row_next;
            col_in   = col_next;
            if (last_cell) begin
               issue_in = '0;
               acc_in   = AW'(push_ff);
               state_in = S_FRC;
            end else begin
               state_in = S_COL_RD;
            end
         end
         S_FRC: begin
            s1_valid_in  = (issue_ff == '0) || (tap_live && nbr_ok);
            s1_centre_in = (issue_ff == '0);
            if (s1_valid_ff && s1_centre_ff) begin
               centre_in = cloth_rd_ff;
            end
            if (mac_rsp.valid) begin
               acc_in = acc_ff + AW'(mac_rsp.result);
            end
            if (issue_ff == SW'(csdf_pkg::ISSUE_LAST)) begin
               issue_in = '0;
               state_in = S_FRC_WR;
            end else begin
               issue_in = issue_ff + 1'b1;
            end
         end
         S_FRC_WR: begin
            force_we = 1'b1;
            acc_in   = AW'(push_ff);
            idx_in   = idx_next;
            row_in   = row_next;
            col_in   = col_next;
            if (last_cell) begin
               vsum_in  = '0;
               state_in = S_UPD_RD;
            end else begin
               state_in = S_FRC;
            end
         end
         S_UPD_RD: state_in = S_UPD_MAC;
         S_UPD_MAC: begin
            vel_new_in = free_rd_ff ? vel_sum : '0;
            state_in   = S_UPD_WR;
         end
         S_UPD_WR: begin
            cloth_we = 1'b1;
            cloth_wd = cloth_new;
            vel_we   = 1'b1;
            vel_wd   = vel_new_ff;
            vsum_in  = vsum_ff + VW'(vel_new_ff);
            idx_in   = idx_next;
            row_in   = row_next;
            col_in   = col_next;
            state_in = last_cell ? S_CHECK : S_UPD_RD;
         end
         S_CHECK: begin
            if (vsum_ff < VW'(thresh_ff)) begin
               conv_in        = 1'b1;
               res_barrier_in = 1'b0;
               res_depth_in   = '0;
               state_in       = S_DONE;
            end else begin
               state_in = S_ITER;
            end
         end
         S_READ_RD: state_in = S_READ_OUT;
         S_READ_OUT: begin
            res_barrier_in = !free_rd_ff;
            res_depth_in   = cloth_rd_ff;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_barrier_in = res_barrier_ff;
               rsp_depth_in   = res_depth_ff;
               rsp_iters_in   = iter_ff;
               rsp_conv_in    = conv_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         ran_ff        <= 1'b0;
         iter_ff       <= '0;
         conv_ff       <= 1'b0;
         s1_valid_ff   <= 1'b0;
         traction_ff   <= 16'd6554;
         shear_ff      <= 16'd3277;
         flexion_ff    <= 16'd1638;
         push_ff       <= '0;
         step_ff       <= 16'd6554;
         thresh_ff     <= '0;
         max_iter_ff   <= 16'd100;
         erase_rows_ff <= 6'd9;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         ran_ff        <= ran_in;
         iter_ff       <= iter_in;
         conv_ff       <= conv_in;
         s1_valid_ff   <= s1_valid_in;
         traction_ff   <= traction_in;
         shear_ff      <= shear_in;
         flexion_ff    <= flexion_in;
         push_ff       <= push_in;
         step_ff       <= step_in;
         thresh_ff     <= thresh_in;
         max_iter_ff   <= max_iter_in;
         erase_rows_ff <= erase_rows_in;
      end
      idx_ff         <= idx_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      cell_ff        <= cell_in;
      issue_ff       <= issue_in;
      min_ff         <= min_in;
      acc_ff         <= acc_in;
      centre_ff      <= centre_in;
      vel_new_ff     <= vel_new_in;
      vsum_ff        <= vsum_in;
      erase_ff       <= erase_in;
      s1_centre_ff   <= s1_centre_in;
      s1_gain_ff     <= s1_gain_in;
      res_barrier_ff <= res_barrier_in;
      res_depth_ff   <= res_depth_in;
      rsp_barrier_ff <= rsp_barrier_in;
      rsp_depth_ff   <= rsp_depth_in;
      rsp_iters_ff   <= rsp_iters_in;
      rsp_conv_ff    <= rsp_conv_in;
   end

   always_ff @(posedge clock) begin
      if (image_we) begin
         image_mem[req_cell] <= image_wd;
      end
      image_rd_ff <= image_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cloth_we) begin
         cloth_mem[idx_ff] <= cloth_wd;
      end
      cloth_rd_ff <= cloth_mem[cloth_raddr];
   end

   always_ff @(posedge clock) begin
      if (vel_we) begin
         vel_mem[idx_ff] <= vel_wd;
      end
      vel_rd_ff <= vel_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (force_we) begin
         force_mem[idx_ff] <= force_wd;
      end
      force_rd_ff <= force_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[idx_ff] <= free_wd;
      end
      free_rd_ff <= free_mem[free_raddr];
   end

endmodule

`default_nettype wire

// ===== src/csdf_checker.sv =====
// ----------------------------------------------------------------------------
// csdf_checker
// Port level checks of the depth filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module csdf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_depth,
   input logic [15:0] rsp_iters,
   input logic        rsp_conv
);

   `CSDF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")
   `CSDF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_depth) && $stable(rsp_iters), "stalled response changed")
   `CSDF_ASSERT(a_busy, clock, reset, req_valid && req_ready && (req_mode == csdf_pkg::MODE_RUN || req_mode == csdf_pkg::MODE_READ) |=> !req_ready, "ready while busy")
   `CSDF_ASSERT(a_conv_iter, clock, reset, rsp_valid && rsp_conv |-> rsp_iters != 16'd0, "converged with no iteration")

endmodule

bind cloth_simulation_depth_filter csdf_checker u_csdf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_mode  (req_bus.mode),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_depth (rsp_bus.cloth_depth),
   .rsp_iters (rsp_bus.iterations_used),
   .rsp_conv  (rsp_bus.converged)
);

`default_nettype wire
